FILE: hdl/sitoa_pkg.sv
// Shared types, constants and helpers for the signed integer to ASCII converter.
package sitoa_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W = 7;
  localparam int DIGIT_W = 6;
  localparam int OUT_DATA_W = 8;
  localparam int DIV_STEPS = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 6'd35;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

  localparam logic [CHAR_W-1:0] MINUS_CODE = 7'h2d;
  localparam logic [CHAR_W-1:0] ZERO_CODE = 7'h30;
  localparam logic [CHAR_W-1:0] LOWER_A_CODE = 7'h61;
  localparam logic [CHAR_W-1:0] ERROR_CODE = 7'h00;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_FETCH,
    S_LOAD,
    S_HOLD
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] dc;
    logic [CHAR_W-1:0] code;
    dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    if (dc < DEC_DIGITS) begin
      code = ZERO_CODE + {1'b0, dc};
    end else begin
      code = LOWER_A_CODE + {1'b0, dc} - {1'b0, DEC_DIGITS};
    end
    return code;
  endfunction

endpackage

FILE: hdl/signed_int_to_ascii_radix.sv
// Signed integer to ASCII text converter with selectable radix.
//
// Input stream (s_axis_*): one word holds a signed value and a radix. The word
// is taken only while the converter is idle; s_axis_tready stays low from the
// accepted word until the last character of its text has been taken.
// Output stream (m_axis_*): one character per word, most significant first, a
// leading '-' for negative values; tlast marks the final character. A radix
// outside 2..36 gives one word with char 0, tlast high and tuser high.
// Timing: the magnitude is divided by the radix in a shared restoring divider
// that retires 4 quotient bits per cycle. The digits are kept in a small store
// and then read back in reverse, most significant first.
// Reset clears the sequencer and the output valid; the digit store is not
// cleared. When the receiver stalls, the output word is held and nothing else
// advances.
module signed_int_to_ascii_radix #(
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [VALUE_BITS-1:0] number, then [5:0] radix, zero padded to whole bytes
  input  logic [((VALUE_BITS + sitoa_pkg::RADIX_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [6:0] char_code, [7] zero
  output logic [sitoa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  // [0] radix_error
  output logic [0:0] m_axis_tuser
);

  localparam int STEPS = sitoa_pkg::DIV_STEPS;
  localparam int NBLK = (VALUE_BITS + STEPS - 1) / STEPS;
  localparam int DW = NBLK * STEPS;
  localparam int BC_W = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int RW = sitoa_pkg::RADIX_W;
  localparam int DGW = sitoa_pkg::DIGIT_W;
  localparam int CW = sitoa_pkg::CHAR_W;

  sitoa_pkg::state_t state, state_next;
  logic [DW-1:0] quo, quo_next;
  logic [DGW-1:0] rem, rem_next;
  logic [RW-1:0] rad, rad_next;
  logic [BC_W-1:0] bit_cnt, bit_cnt_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic neg, neg_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic out_valid, out_valid_next;
  logic [CW-1:0] out_char, out_char_next;
  logic out_last, out_last_next;
  logic out_err, out_err_next;

  logic [DGW-1:0] store [VALUE_BITS];
  logic [DGW-1:0] rd_data;
  logic st_wr;

  logic [VALUE_BITS-1:0] in_num;
  logic [RW-1:0] in_rad;
  logic in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic rad_ok;
  logic in_take;
  logic out_take;

  logic [DW-1:0] quo_step;
  logic [DGW-1:0] rem_step;
  logic [CNT_W-1:0] cnt_inc;

  assign in_num = s_axis_tdata[VALUE_BITS-1:0];
  assign in_rad = s_axis_tdata[VALUE_BITS +: RW];
  assign in_neg = in_num[VALUE_BITS-1];
  assign in_mag = in_neg ? (~in_num + 1'b1) : in_num;
  assign rad_ok = (in_rad >= sitoa_pkg::RADIX_MIN) && (in_rad <= sitoa_pkg::RADIX_MAX);
  assign s_axis_tready = (state == sitoa_pkg::S_IDLE);
  assign in_take = s_axis_tvalid && s_axis_tready;
  assign out_take = out_valid && m_axis_tready;
  assign cnt_inc = cnt + 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {{(sitoa_pkg::OUT_DATA_W - CW){1'b0}}, out_char};
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_err;

  // Restoring divider slice: retire STEPS quotient bits.
  always_comb begin
    logic [DW-1:0] q;
    logic [DGW-1:0] r;
    logic [DGW:0] t;
    logic ge;
    q = quo;
    r = rem;
    for (int k = 0; k < STEPS; k++) begin
      t = {r, q[DW-1]};
      ge = (t >= {1'b0, rad});
      r = ge ? DGW'(t - {1'b0, rad}) : t[DGW-1:0];
      q = {q[DW-2:0], ge};
    end
    quo_step = q;
    rem_step = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sitoa_pkg::S_IDLE;
      cnt <= '0;
      neg <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      neg <= neg_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    quo <= quo_next;
    rem <= rem_next;
    rad <= rad_next;
    bit_cnt <= bit_cnt_next;
    idx <= idx_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
    out_err <= out_err_next;
  end

  always_ff @(posedge clk) begin
    if (st_wr) begin
      store[cnt[IDX_W-1:0]] <= rem_step;
    end
    rd_data <= store[idx];
  end

  always_comb begin
    state_next = state;
    quo_next = quo;
    rem_next = rem;
    rad_next = rad;
    bit_cnt_next = bit_cnt;
    cnt_next = cnt;
    neg_next = neg;
    idx_next = idx;
    out_valid_next = out_valid;
    out_char_next = out_char;
    out_last_next = out_last;
    out_err_next = out_err;
    st_wr = 1'b0;
    case (state)
      sitoa_pkg::S_IDLE: begin
        if (in_take) begin
          if (!rad_ok) begin
            cnt_next = '0;
            neg_next = 1'b0;
            out_valid_next = 1'b1;
            out_char_next = sitoa_pkg::ERROR_CODE;
            out_last_next = 1'b1;
            out_err_next = 1'b1;
            state_next = sitoa_pkg::S_HOLD;
          end else begin
            quo_next = DW'(in_mag);
            rem_next = '0;
            rad_next = in_rad;
            bit_cnt_next = BC_W'(NBLK - 1);
            cnt_next = '0;
            neg_next = in_neg;
            state_next = sitoa_pkg::S_DIV;
          end
        end
      end
      sitoa_pkg::S_DIV: begin
        if (bit_cnt == '0) begin
          st_wr = 1'b1;
          cnt_next = cnt_inc;
          if ((quo_step == '0) || (cnt_inc == CNT_W'(VALUE_BITS))) begin
            idx_next = cnt[IDX_W-1:0];
            state_next = neg ? sitoa_pkg::S_SIGN : sitoa_pkg::S_FETCH;
          end else begin
            quo_next = quo_step;
            rem_next = '0;
            bit_cnt_next = BC_W'(NBLK - 1);
          end
        end else begin
          quo_next = quo_step;
          rem_next = rem_step;
          bit_cnt_next = bit_cnt - 1'b1;
        end
      end
      sitoa_pkg::S_SIGN: begin
        out_valid_next = 1'b1;
        out_char_next = sitoa_pkg::MINUS_CODE;
        out_last_next = 1'b0;
        out_err_next = 1'b0;
        state_next = sitoa_pkg::S_HOLD;
      end
      sitoa_pkg::S_FETCH: begin
        state_next = sitoa_pkg::S_LOAD;
      end
      sitoa_pkg::S_LOAD: begin
        out_valid_next = 1'b1;
        out_char_next = sitoa_pkg::digit_char(rd_data);
        out_last_next = (idx == '0);
        out_err_next = 1'b0;
        if (idx != '0) begin
          idx_next = idx - 1'b1;
        end
        state_next = sitoa_pkg::S_HOLD;
      end
      sitoa_pkg::S_HOLD: begin
        if (out_take) begin
          out_valid_next = 1'b0;
          state_next = out_last ? sitoa_pkg::S_IDLE : sitoa_pkg::S_FETCH;
        end
      end
      default: begin
        state_next = sitoa_pkg::S_IDLE;
        out_valid_next = 1'b0;
      end
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a word is pending");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err) |-> (out_last && (out_char == sitoa_pkg::ERROR_CODE)))
    else $error("error word malformed");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_take && out_last) |=> s_axis_tready)
    else $error("not ready after final word");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(VALUE_BITS))
    else $error("digit count overflow");

  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    (state == sitoa_pkg::S_SIGN) |-> (neg && $past(state) == sitoa_pkg::S_DIV))
    else $error("sign emitted out of order");

endmodule

FILE: dv/tb_signed_int_to_ascii_radix.sv
// Testbench for the signed integer to ASCII radix converter: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module tb_signed_int_to_ascii_radix;

  localparam int VALUE_BITS = 32;
  localparam int IN_W = ((VALUE_BITS + sitoa_pkg::RADIX_W + 7) / 8) * 8;
  localparam int IDLE_PCT = 22;
  localparam int HOLDOFF_AT = 150;
  localparam int HOLDOFF_CYCLES = 500;
  localparam int CALM_FROM = 400;
  localparam int CALM_TO = 900;
  localparam int RANDOM_WORDS = 238;

  typedef struct packed {
    logic [sitoa_pkg::CHAR_W-1:0] code;
    logic last;
    logic radix_err;
  } text_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [sitoa_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [0:0] m_axis_tuser;

  logic [IN_W-1:0] pending_words[$];
  text_char_t expected_chars[$];
  int error_count = 0;
  int chars_seen = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  bit calm;

  assign calm = (chars_seen >= CALM_FROM) && (chars_seen < CALM_TO);

  signed_int_to_ascii_radix #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected characters of one conversion, most significant first.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] number,
                                       input logic [sitoa_pkg::RADIX_W-1:0] radix);
    logic [VALUE_BITS-1:0] mag;
    logic [sitoa_pkg::DIGIT_W-1:0] digits [VALUE_BITS];
    logic [sitoa_pkg::DIGIT_W-1:0] d;
    text_char_t c;
    int n;
    int i;
    if (radix < sitoa_pkg::RADIX_MIN || radix > sitoa_pkg::RADIX_MAX) begin
      c.code = sitoa_pkg::ERROR_CODE;
      c.last = 1'b1;
      c.radix_err = 1'b1;
      expected_chars.push_back(c);
      return;
    end
    mag = number[VALUE_BITS-1] ? -number : number;
    n = 0;
    do begin
      digits[n] = sitoa_pkg::DIGIT_W'(mag % radix);
      n++;
      mag = mag / radix;
    end while (mag != 0 && n < VALUE_BITS);
    if (number[VALUE_BITS-1]) begin
      c.code = sitoa_pkg::MINUS_CODE;
      c.last = 1'b0;
      c.radix_err = 1'b0;
      expected_chars.push_back(c);
    end
    for (i = n - 1; i >= 0; i--) begin
      d = digits[i];
      c.code = (d < sitoa_pkg::DEC_DIGITS) ? sitoa_pkg::ZERO_CODE + d :
               sitoa_pkg::LOWER_A_CODE + d - sitoa_pkg::DEC_DIGITS;
      c.last = (i == 0);
      c.radix_err = 1'b0;
      expected_chars.push_back(c);
    end
  endfunction

  task automatic add_word(input logic [VALUE_BITS-1:0] number,
                          input logic [sitoa_pkg::RADIX_W-1:0] radix);
    pending_words.push_back(IN_W'({radix, number}));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid)
        predict_text(s_axis_tdata[VALUE_BITS-1:0],
                     s_axis_tdata[VALUE_BITS +: sitoa_pkg::RADIX_W]);
      if (pending_words.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_words.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    text_char_t exp_c;
    text_char_t got_c;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_c.code = m_axis_tdata[sitoa_pkg::CHAR_W-1:0];
        got_c.last = m_axis_tlast;
        got_c.radix_err = m_axis_tuser[0];
        chars_seen <= chars_seen + 1;
        if (expected_chars.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word: expected none, actual code %h last %b err %b",
                   $time, got_c.code, got_c.last, got_c.radix_err);
        end else begin
          exp_c = expected_chars.pop_front();
          if (got_c.code !== exp_c.code) begin
            error_count++;
            $display("%0t: char_code: expected %h, actual %h", $time, exp_c.code, got_c.code);
          end
          if (got_c.last !== exp_c.last) begin
            error_count++;
            $display("%0t: last: expected %b, actual %b", $time, exp_c.last, got_c.last);
          end
          if (got_c.radix_err !== exp_c.radix_err) begin
            error_count++;
            $display("%0t: radix_error: expected %b, actual %b",
                     $time, exp_c.radix_err, got_c.radix_err);
          end
        end
      end
      if (!holdoff_done && chars_seen >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    logic [VALUE_BITS-1:0] number;
    logic [sitoa_pkg::RADIX_W-1:0] radix;
    add_word(32'd0, 6'd10);
    add_word(32'hffffffff, 6'd10);
    add_word(32'h7fffffff, 6'd10);
    add_word(32'h80000000, 6'd10);
    add_word(32'h80000000, 6'd2);
    add_word(32'h7fffffff, 6'd2);
    add_word(32'hffffffff, 6'd2);
    add_word(32'h80000000, 6'd36);
    add_word(32'h7fffffff, 6'd36);
    add_word(32'd35, 6'd36);
    add_word(32'd0, 6'd2);
    add_word(32'd0, 6'd36);
    add_word(32'd1234, 6'd0);
    add_word(32'hffffffff, 6'd1);
    add_word(32'd7, 6'd37);
    add_word(32'h80000000, 6'd63);
    add_word(-32'sd255, 6'd16);
    add_word(32'd12345, 6'd8);
    add_word(32'd1, 6'd3);
    add_word(32'h55555555, 6'd4);
    add_word(32'haaaaaaaa, 6'd7);
    add_word(-32'sd36, 6'd36);
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      case ($urandom_range(3))
        0: number = $urandom;
        1: number = $urandom_range(40);
        2: number = -$urandom_range(5000, 1);
        default: begin
          case ($urandom_range(3))
            0: number = 32'h80000000;
            1: number = 32'h7fffffff;
            2: number = 32'hffffffff;
            default: number = 32'h80000001;
          endcase
        end
      endcase
      if ($urandom_range(9) == 0) begin
        radix = $urandom_range(1) ? sitoa_pkg::RADIX_W'($urandom_range(1)) :
                sitoa_pkg::RADIX_W'($urandom_range(63, 37));
      end else if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0: radix = 6'd2;
          1: radix = 6'd8;
          2: radix = 6'd10;
          3: radix = 6'd16;
          default: radix = 6'd36;
        endcase
      end else begin
        radix = sitoa_pkg::RADIX_W'($urandom_range(36, 2));
      end
      add_word(number, radix);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (expected_chars.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
